FILE: sv/rvx_pkg.sv
// Shared types, opcodes and status codes for the RV32IM execute core.
package rvx_pkg;
   localparam int MEM_BYTES = 65536;
   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int CLEAR_ROWS = MEM_BYTES / 4;
   localparam int CLEAR_AW = $clog2(CLEAR_ROWS);

   localparam logic [6:0] OP_LUI = 7'h37;
   localparam logic [6:0] OP_AUIPC = 7'h17;
   localparam logic [6:0] OP_JAL = 7'h6f;
   localparam logic [6:0] OP_JALR = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD = 7'h03;
   localparam logic [6:0] OP_STORE = 7'h23;
   localparam logic [6:0] OP_IMM = 7'h13;
   localparam logic [6:0] OP_REG = 7'h33;
   localparam logic [31:0] EBREAK_WORD = 32'h00100073;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EBREAK = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_STOPPED = 2'd3;

   localparam logic [0:0] CSR_START_PC = 1'd0;

   typedef struct packed {
      logic [31:0] instruction;
   } entry_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        store_done;
      logic [31:0] mem_address;
      logic [1:0]  status;
      logic [31:0] halt_code;
   } result_type;
endpackage

FILE: sv/rvx_front.sv
// Front end: accepts instruction transfers into a short queue.
module rvx_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_instruction,
   output logic                q_valid,
   output rvx_pkg::entry_type  q_entry,
   input  logic                q_take
);
   import rvx_pkg::*;
   localparam int PW = $clog2(QUEUE_DEPTH);
   entry_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign req_stall = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_take;
   assign q_entry = mem_ff[rp_ff];

   always_comb begin
      wp_in = push ? ((wp_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in = pop ? ((rp_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff].instruction <= req_instruction;
   end
endmodule

FILE: sv/rvx_divider.sv
// Iterative radix-2 unsigned divider, one quotient bit per cycle.
module rvx_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   assign trial = {r_ff, q_ff[31]} - {1'b0, d_ff};
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         n_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         n_ff <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= divisor;
   end
   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

FILE: sv/rvx_back.sv
// Back end: executes queued instructions against registers and data memory.
module rvx_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         start_pc,
   input  logic                q_valid,
   input  rvx_pkg::entry_type  q_entry,
   output logic                q_take,
   output logic                res_valid,
   output rvx_pkg::result_type res,
   input  logic                res_stall
);
   import rvx_pkg::*;
   localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_LOAD = 3'd2,
                          S_MULH = 3'd3, S_DIVW = 3'd4, S_DIVF = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [CLEAR_AW-1:0] clr_ff;
   logic [31:0] pc_ff, pc_in;
   logic        stop_ff, stop_in;
   logic [31:0] rf_ff [32];
   logic [7:0]  mem0 [CLEAR_ROWS], mem1 [CLEAR_ROWS], mem2 [CLEAR_ROWS],
                mem3 [CLEAR_ROWS];
   logic [31:0] w_ff;
   logic [31:0] a_ff, b_ff;
   logic        ov_ff;
   result_type  out_ff, out_in;
   logic        ov_in;
   logic        can_go;
   logic [7:0]  rd0_ff, rd1_ff, rd2_ff, rd3_ff;
   logic [63:0] prod_ff;
   logic        neg_ff;
   logic        dstart;
   logic        ddone;
   logic [31:0] dq, dr;

   logic [31:0] w, a, b, immi, imms, immb, immj, immu, npc, val, maddr;
   logic [6:0]  op;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [4:0]  rd;
   logic        wr, st, inv, tk, slt, sltu;
   logic [1:0]  stat;
   logic [2:0]  go_state;

   logic [31:0] la;
   logic [MEM_AW-1:0] ab [4];
   logic [MEM_AW-1:0] sa [4];
   logic [3:0]  sen;
   logic [7:0]  sdat [4];
   logic [31:0] ldraw;
   logic [31:0] ma, mb;
   logic        na, nb;
   logic [31:0] fin;

   assign w = q_entry.instruction;
   assign op = w[6:0];
   assign rd = w[11:7];
   assign f3 = w[14:12];
   assign f7 = w[31:25];
   assign a = rf_ff[w[19:15]];
   assign b = rf_ff[w[24:20]];
   assign immi = {{20{w[31]}}, w[31:20]};
   assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
   assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
   assign immu = {w[31:12], 12'd0};

   assign can_go = (state_ff == S_IDLE) && q_valid && (!ov_ff || !res_stall);
   assign q_take = can_go;

   always_comb begin
      npc = pc_ff + 32'd4;
      wr = 1'b0;
      st = 1'b0;
      inv = 1'b0;
      val = '0;
      maddr = '0;
      stat = ST_OK;
      tk = 1'b0;
      go_state = S_IDLE;
      slt = 1'b0;
      sltu = 1'b0;
      case (op)
         OP_LUI: begin wr = 1'b1; val = immu; end
         OP_AUIPC: begin wr = 1'b1; val = pc_ff + immu; end
         OP_JAL: begin wr = 1'b1; val = pc_ff + 32'd4; npc = pc_ff + immj; end
         OP_JALR: begin
            if (f3 != 3'd0) inv = 1'b1;
            else begin
               wr = 1'b1;
               val = pc_ff + 32'd4;
               npc = (a + immi) & ~32'd1;
            end
         end
         OP_BRANCH: begin
            slt = $signed(a) < $signed(b);
            sltu = a < b;
            case (f3)
               3'd0: tk = a == b;
               3'd1: tk = a != b;
               3'd4: tk = slt;
               3'd5: tk = !slt;
               3'd6: tk = sltu;
               3'd7: tk = !sltu;
               default: inv = 1'b1;
            endcase
            if (tk) npc = pc_ff + immb;
         end
         OP_LOAD: begin
            maddr = a + immi;
            wr = 1'b1;
            if (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5}) go_state = S_LOAD;
            else inv = 1'b1;
         end
         OP_STORE: begin
            if (f3 > 3'd2) inv = 1'b1;
            else begin
               maddr = a + imms;
               st = 1'b1;
            end
         end
         OP_IMM: begin
            wr = 1'b1;
            case (f3)
               3'd0: val = a + immi;
               3'd2: val = {31'd0, $signed(a) < $signed(immi)};
               3'd3: val = {31'd0, a < immi};
               3'd4: val = a ^ immi;
               3'd6: val = a | immi;
               3'd7: val = a & immi;
               3'd1: begin
                  if (f7 != 7'd0) inv = 1'b1;
                  else val = a << immi[4:0];
               end
               default: begin
                  if (f7 == 7'd0) val = a >> immi[4:0];
                  else if (f7 == 7'h20) val = 32'($signed(a) >>> immi[4:0]);
                  else inv = 1'b1;
               end
            endcase
         end
         OP_REG: begin
            wr = 1'b1;
            if (f7 == 7'd0) begin
               case (f3)
                  3'd0: val = a + b;
                  3'd1: val = a << b[4:0];
                  3'd2: val = {31'd0, $signed(a) < $signed(b)};
                  3'd3: val = {31'd0, a < b};
                  3'd4: val = a ^ b;
                  3'd5: val = a >> b[4:0];
                  3'd6: val = a | b;
                  default: val = a & b;
               endcase
            end else if (f7 == 7'h20) begin
               if (f3 == 3'd0) val = a - b;
               else if (f3 == 3'd5) val = 32'($signed(a) >>> b[4:0]);
               else inv = 1'b1;
            end else if (f7 == 7'd1) begin
               if (f3[2]) go_state = S_DIVW;
               else go_state = S_MULH;
            end else inv = 1'b1;
         end
         default: begin
            if (w == EBREAK_WORD) stat = ST_EBREAK;
            else inv = 1'b1;
         end
      endcase
      if (inv) begin
         wr = 1'b0;
         st = 1'b0;
         val = '0;
         maddr = '0;
         npc = pc_ff + 32'd4;
         stat = ST_INVALID;
         go_state = S_IDLE;
      end
      if (stop_ff) begin
         wr = 1'b0;
         st = 1'b0;
         maddr = '0;
         npc = pc_ff;
         stat = ST_STOPPED;
         go_state = S_IDLE;
      end
      if (!wr || rd == 5'd0) begin
         wr = 1'b0;
         val = '0;
      end
   end

   // operand magnitudes for multiply and divide
   always_comb begin
      na = a[31] && (f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd6);
      nb = b[31] && (f3 == 3'd1 || f3 == 3'd4 || f3 == 3'd6);
      ma = na ? 32'd0 - a : a;
      mb = nb ? 32'd0 - b : b;
   end
   assign dstart = can_go && go_state == S_DIVW;

   rvx_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(ma), .divisor(mb),
      .done(ddone), .quotient(dq), .remainder(dr)
   );

   always_comb begin
      la = (state_ff == S_IDLE) ? maddr : out_ff.mem_address;
      for (int k = 0; k < 4; k++) begin
         ab[k] = MEM_AW'(la + 32'(k));
         sa[k] = MEM_AW'(maddr + 32'(k));
      end
      sen = '0;
      if (can_go && st) begin
         sen[0] = 1'b1;
         sen[1] = f3[1:0] != 2'd0;
         sen[2] = f3[1];
         sen[3] = f3[1];
      end
      sdat[0] = b[7:0];
      sdat[1] = b[15:8];
      sdat[2] = b[23:16];
      sdat[3] = b[31:24];
   end

   // byte k of an access lands in bank (addr+k)[1:0]
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         mem0[clr_ff] <= '0;
         mem1[clr_ff] <= '0;
         mem2[clr_ff] <= '0;
         mem3[clr_ff] <= '0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (sen[k]) begin
               case (sa[k][1:0])
                  2'd0: mem0[sa[k][MEM_AW-1:2]] <= sdat[k];
                  2'd1: mem1[sa[k][MEM_AW-1:2]] <= sdat[k];
                  2'd2: mem2[sa[k][MEM_AW-1:2]] <= sdat[k];
                  default: mem3[sa[k][MEM_AW-1:2]] <= sdat[k];
               endcase
            end
         end
      end
      rd0_ff <= mem0[ab[0][1:0] == 2'd0 ? ab[0][MEM_AW-1:2] :
                     (ab[3][1:0] == 2'd0 ? ab[3][MEM_AW-1:2] :
                     (ab[2][1:0] == 2'd0 ? ab[2][MEM_AW-1:2] : ab[1][MEM_AW-1:2]))];
      rd1_ff <= mem1[ab[0][1:0] == 2'd1 ? ab[0][MEM_AW-1:2] :
                     (ab[3][1:0] == 2'd1 ? ab[3][MEM_AW-1:2] :
                     (ab[2][1:0] == 2'd1 ? ab[2][MEM_AW-1:2] : ab[1][MEM_AW-1:2]))];
      rd2_ff <= mem2[ab[0][1:0] == 2'd2 ? ab[0][MEM_AW-1:2] :
                     (ab[3][1:0] == 2'd2 ? ab[3][MEM_AW-1:2] :
                     (ab[2][1:0] == 2'd2 ? ab[2][MEM_AW-1:2] : ab[1][MEM_AW-1:2]))];
      rd3_ff <= mem3[ab[0][1:0] == 2'd3 ? ab[0][MEM_AW-1:2] :
                     (ab[3][1:0] == 2'd3 ? ab[3][MEM_AW-1:2] :
                     (ab[2][1:0] == 2'd3 ? ab[2][MEM_AW-1:2] : ab[1][MEM_AW-1:2]))];
   end

   always_comb begin
      ldraw = '0;
      case (la[1:0])
         2'd0: ldraw = {rd3_ff, rd2_ff, rd1_ff, rd0_ff};
         2'd1: ldraw = {rd0_ff, rd3_ff, rd2_ff, rd1_ff};
         2'd2: ldraw = {rd1_ff, rd0_ff, rd3_ff, rd2_ff};
         default: ldraw = {rd2_ff, rd1_ff, rd0_ff, rd3_ff};
      endcase
      fin = '0;
      case (w_ff[14:12])
         3'd0: fin = {{24{ldraw[7]}}, ldraw[7:0]};
         3'd1: fin = {{16{ldraw[15]}}, ldraw[15:0]};
         3'd4: fin = {24'd0, ldraw[7:0]};
         3'd5: fin = {16'd0, ldraw[15:0]};
         default: fin = ldraw;
      endcase
   end

   logic [63:0] pfix;
   logic [31:0] dres;
   always_comb begin
      pfix = neg_ff ? 64'd0 - prod_ff : prod_ff;
      if (b_ff == 32'd0) dres = w_ff[13] ? a_ff : 32'hffffffff;
      else if (w_ff[12] == 1'b0 && a_ff == 32'h80000000 && b_ff == 32'hffffffff)
         dres = w_ff[13] ? 32'd0 : 32'h80000000;
      else if (w_ff[13]) dres = (w_ff[12] == 1'b0 && a_ff[31]) ? 32'd0 - dr : dr;
      else dres = (w_ff[12] == 1'b0 && (a_ff[31] != b_ff[31])) ? 32'd0 - dq : dq;
   end

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      stop_in = stop_ff;
      out_in = out_ff;
      ov_in = ov_ff && res_stall;
      case (state_ff)
         S_CLEAR: if (clr_ff == CLEAR_AW'(CLEAR_ROWS-1)) state_in = S_IDLE;
         S_IDLE: begin
            if (can_go) begin
               pc_in = npc;
               if (stat == ST_EBREAK || stat == ST_INVALID) stop_in = 1'b1;
               out_in.next_pc = npc;
               out_in.reg_write = wr;
               out_in.reg_index = wr ? rd : 5'd0;
               out_in.reg_value = val;
               out_in.store_done = st;
               out_in.mem_address = maddr;
               out_in.status = stat;
               out_in.halt_code = (stat == ST_EBREAK) ? rf_ff[10] : 32'd0;
               state_in = go_state;
               ov_in = (go_state == S_IDLE);
            end
         end
         S_LOAD: begin
            state_in = S_IDLE;
            ov_in = 1'b1;
            if (out_ff.reg_write) out_in.reg_value = fin;
         end
         S_MULH: begin
            state_in = S_IDLE;
            ov_in = 1'b1;
            if (out_ff.reg_write)
               out_in.reg_value = (w_ff[13:12] == 2'd0) ? pfix[31:0] : pfix[63:32];
         end
         S_DIVW: if (ddone) state_in = S_DIVF;
         S_DIVF: begin
            state_in = S_IDLE;
            ov_in = 1'b1;
            if (out_ff.reg_write) out_in.reg_value = dres;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pc_ff <= start_pc;
         stop_ff <= 1'b0;
         ov_ff <= 1'b0;
         for (int i = 0; i < 32; i++) rf_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_ff + 1'b1;
         pc_ff <= pc_in;
         stop_ff <= stop_in;
         ov_ff <= ov_in;
         if (can_go && wr) rf_ff[rd] <= val;
         if (state_ff != S_IDLE && state_in == S_IDLE && state_ff != S_CLEAR
             && out_ff.reg_write)
            rf_ff[out_ff.reg_index] <= out_in.reg_value;
      end
      out_ff <= out_in;
      if (can_go) begin
         w_ff <= w;
         a_ff <= a;
         b_ff <= b;
         prod_ff <= 64'(ma) * 64'(mb);
         neg_ff <= na != nb;
      end
   end

   assign res_valid = ov_ff;
   assign res = out_ff;
endmodule

FILE: sv/rv32im_instruction_execute_core.sv
// Top level of the RV32IM instruction execute core.
// Usage:
//  The req_ channel transfers one instruction word per item, fetched at the
//  core's program counter. The rsp_ channel returns one result per item:
//  next PC, register write, store flag, memory address, status, halt code.
//  A two-entry queue sits between the front end and the execute back end.
//  ALU, branch, jump and store items pass the queue and then the result
//  register and issue every cycle while rsp_stall is low; loads and
//  multiplies also pass S_LOAD or S_MULH, divides wait in the radix-2
//  divider, and each of these holds off the next item until it is done.
//  A following item issues only once the result register is free, so a
//  stalled rsp_ side holds results and backs up into the queue and req_stall.
//  Reset: the PC loads start_pc, registers and the stopped flag clear, and
//  a clearing pass zeroes the data memory one word a cycle; items queue
//  but do not execute during it. start_pc is written at paddr 0 of the
//  psel/penable port and takes effect at the next reset.
module rv32im_instruction_execute_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instruction,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_store_done,
   output logic [31:0] rsp_mem_address,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_halt_code,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rvx_pkg::*;
   logic [31:0] start_pc_ff;
   logic        q_valid, q_take;
   entry_type   q_entry;
   result_type  res;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) start_pc_ff <= 32'h80000000;
      else if (psel && penable && pwrite && paddr[2] == CSR_START_PC && paddr[1:0] == 2'd0)
         start_pc_ff <= pwdata;
   end
   assign prdata = (paddr[2] == CSR_START_PC) ? start_pc_ff : 32'd0;

   rvx_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_instruction(req_instruction), .q_valid(q_valid), .q_entry(q_entry),
      .q_take(q_take)
   );

   rvx_back u_back (
      .clock(clock), .reset(reset), .start_pc(start_pc_ff), .q_valid(q_valid),
      .q_entry(q_entry), .q_take(q_take), .res_valid(rsp_valid), .res(res),
      .res_stall(rsp_stall)
   );

   assign rsp_next_pc = res.next_pc;
   assign rsp_reg_write = res.reg_write;
   assign rsp_reg_index = res.reg_index;
   assign rsp_reg_value = res.reg_value;
   assign rsp_store_done = res.store_done;
   assign rsp_mem_address = res.mem_address;
   assign rsp_status = res.status;
   assign rsp_halt_code = res.halt_code;
endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the RV32IM instruction execute core.
module tb_top;
   import rvx_pkg::*;

   localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
   localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
   localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2, F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;
   localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2, F3_MULHU = 3'd3;
   localparam logic [2:0] F3_DIV = 3'd4, F3_DIVU = 3'd5, F3_REM = 3'd6, F3_REMU = 3'd7;
   localparam logic [6:0] F7_BASE = 7'h00, F7_ALT = 7'h20, F7_MULDIV = 7'h01;
   localparam logic [31:0] ECALL_WORD = 32'h00000073;
   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   logic [31:0] req_instruction = 0;
   logic req_stall, rsp_valid;
   logic [31:0] rsp_next_pc, rsp_reg_value, rsp_mem_address, rsp_halt_code;
   logic rsp_reg_write, rsp_store_done;
   logic [4:0] rsp_reg_index;
   logic [1:0] rsp_status;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic pready;

   rv32im_instruction_execute_core uut (.*);

   always #5 clock = ~clock;

   logic [31:0] arch_pc, cfg_start_pc;
   logic [31:0] arch_reg [0:31];
   logic [7:0] arch_mem [0:MEM_BYTES-1];
   logic arch_halted;
   result_type pending_results [$];
   int mismatches = 0, cycles = 0;
   bit quiet = 0;

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] load_bytes(logic [31:0] addr, int n);
      logic [31:0] v;
      logic [15:0] a;
      v = 0;
      for (int k = 0; k < n; k++) begin
         a = addr[15:0] + k[15:0];
         v[8*k +: 8] = arch_mem[a];
      end
      return v;
   endfunction

   task automatic execute_word(input logic [31:0] w, output result_type r);
      logic [6:0] op, f7;
      logic [4:0] rd;
      logic [2:0] f3;
      logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u, pc, npc, val, maddr, hc;
      logic signed [63:0] prod;
      logic [15:0] ba;
      logic wr, st, inv, tk;
      logic [1:0] stat;
      r = '0;
      pc = arch_pc;
      if (arch_halted) begin
         r.next_pc = pc;
         r.status = ST_STOPPED;
         return;
      end
      op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
      a = arch_reg[w[19:15]]; b = arch_reg[w[24:20]];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      imm_u = {w[31:12], 12'b0};
      npc = pc + 4; wr = 0; st = 0; inv = 0; val = 0; maddr = 0; stat = ST_OK; hc = 0;
      case (op)
         OP_LUI: begin wr = 1; val = imm_u; end
         OP_AUIPC: begin wr = 1; val = pc + imm_u; end
         OP_JAL: begin wr = 1; val = pc + 4; npc = pc + imm_j; end
         OP_JALR: begin
            if (f3 != 0) inv = 1;
            else begin wr = 1; val = pc + 4; npc = (a + imm_i) & ~32'd1; end
         end
         OP_BRANCH: begin
            tk = 0;
            case (f3)
               F3_BEQ: tk = a == b;
               F3_BNE: tk = a != b;
               F3_BLT: tk = $signed(a) < $signed(b);
               F3_BGE: tk = $signed(a) >= $signed(b);
               F3_BLTU: tk = a < b;
               F3_BGEU: tk = a >= b;
               default: inv = 1;
            endcase
            if (tk) npc = pc + imm_b;
         end
         OP_LOAD: begin
            maddr = a + imm_i; wr = 1;
            case (f3)
               F3_LB: begin val = load_bytes(maddr, 1); val = {{24{val[7]}}, val[7:0]}; end
               F3_LH: begin val = load_bytes(maddr, 2); val = {{16{val[15]}}, val[15:0]}; end
               F3_LW: val = load_bytes(maddr, 4);
               F3_LBU: val = load_bytes(maddr, 1);
               F3_LHU: val = load_bytes(maddr, 2);
               default: inv = 1;
            endcase
         end
         OP_STORE: begin
            if (f3 > 2) inv = 1;
            else begin
               maddr = a + imm_s; st = 1;
               for (int k = 0; k < (1 << f3); k++) begin
                  ba = maddr[15:0] + k[15:0];
                  arch_mem[ba] = b[8*k +: 8];
               end
            end
         end
         OP_IMM: begin
            wr = 1;
            case (f3)
               F3_ADD: val = a + imm_i;
               F3_SLT: val = ($signed(a) < $signed(imm_i)) ? 1 : 0;
               F3_SLTU: val = (a < imm_i) ? 1 : 0;
               F3_XOR: val = a ^ imm_i;
               F3_OR: val = a | imm_i;
               F3_AND: val = a & imm_i;
               F3_SLL: if (f7 != F7_BASE) inv = 1; else val = a << imm_i[4:0];
               default: begin
                  if (f7 == F7_BASE) val = a >> imm_i[4:0];
                  else if (f7 == F7_ALT) val = $signed(a) >>> imm_i[4:0];
                  else inv = 1;
               end
            endcase
         end
         OP_REG: begin
            wr = 1;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD: val = a + b;
                  F3_SLL: val = a << b[4:0];
                  F3_SLT: val = ($signed(a) < $signed(b)) ? 1 : 0;
                  F3_SLTU: val = (a < b) ? 1 : 0;
                  F3_XOR: val = a ^ b;
                  F3_SR: val = a >> b[4:0];
                  F3_OR: val = a | b;
                  default: val = a & b;
               endcase
            end else if (f7 == F7_ALT) begin
               if (f3 == F3_ADD) val = a - b;
               else if (f3 == F3_SR) val = $signed(a) >>> b[4:0];
               else inv = 1;
            end else if (f7 == F7_MULDIV) begin
               case (f3)
                  F3_MUL: val = a * b;
                  F3_MULH: begin
                     prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                     val = prod[63:32];
                  end
                  F3_MULHSU: begin
                     prod = $signed({{32{a[31]}}, a}) * $signed({32'b0, b});
                     val = prod[63:32];
                  end
                  F3_MULHU: begin prod = {32'b0, a} * {32'b0, b}; val = prod[63:32]; end
                  F3_DIV: begin
                     if (b == 0) val = 32'hffffffff;
                     else if (a == 32'h80000000 && b == 32'hffffffff) val = a;
                     else val = $signed(a) / $signed(b);
                  end
                  F3_DIVU: val = (b == 0) ? 32'hffffffff : a / b;
                  F3_REM: begin
                     if (b == 0) val = a;
                     else if (a == 32'h80000000 && b == 32'hffffffff) val = 0;
                     else val = $signed(a) % $signed(b);
                  end
                  default: val = (b == 0) ? a : a % b;
               endcase
            end else inv = 1;
         end
         default: begin
            if (w == EBREAK_WORD) begin
               stat = ST_EBREAK; hc = arch_reg[10]; arch_halted = 1;
            end else inv = 1;
         end
      endcase
      if (inv) begin
         wr = 0; st = 0; val = 0; maddr = 0; npc = pc + 4; stat = ST_INVALID; arch_halted = 1;
      end
      if (wr && rd != 0) arch_reg[rd] = val;
      else begin wr = 0; rd = 0; val = 0; end
      arch_pc = npc;
      r.next_pc = npc; r.reg_write = wr; r.reg_index = rd; r.reg_value = val;
      r.store_done = st; r.mem_address = maddr; r.status = stat; r.halt_code = hc;
   endtask

   task automatic send_instruction(input logic [31:0] w);
      result_type r;
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 0;
         gap = $urandom_range(1, 7);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_instruction = w;
      do @(posedge clock); while (req_stall);
      execute_word(w, r);
      pending_results.push_back(r);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_start_pc(input logic [31:0] v);
      @(negedge clock);
      psel = 1; pwrite = 1; penable = 0; paddr = {CSR_START_PC, 2'b00}; pwdata = v;
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 0; penable = 0; pwrite = 0;
      cfg_start_pc = v;
   endtask

   function automatic logic [31:0] random_word();
      logic [4:0] rd, rs1, rs2;
      logic [11:0] imm;
      logic [2:0] f3;
      rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom); imm = 12'($urandom);
      f3 = 3'($urandom);
      case ($urandom_range(0, 11))
         0: return {20'($urandom_range(0, 32'hfffff)), rd, OP_LUI};
         1: return {20'($urandom_range(0, 32'hfffff)), rd, OP_AUIPC};
         2, 3: begin
            if (f3 == F3_SLL) return enc_r(F7_BASE, imm[4:0], rs1, f3, rd, OP_IMM);
            if (f3 == F3_SR)
               return enc_r($urandom_range(0, 1) ? F7_ALT : F7_BASE, imm[4:0], rs1, f3, rd,
                            OP_IMM);
            return enc_i(imm, rs1, f3, rd, OP_IMM);
         end
         4: begin
            if ($urandom_range(0, 1)) return enc_r(F7_BASE, rs2, rs1, f3, rd, OP_REG);
            return enc_r(F7_ALT, rs2, rs1, $urandom_range(0, 1) ? F3_SR : F3_ADD, rd, OP_REG);
         end
         5, 6: return enc_r(F7_MULDIV, rs2, rs1, f3, rd, OP_REG);
         7: begin
            f3 = 3'($urandom_range(0, 4));
            if (f3 == 3'd3) f3 = F3_LHU;
            if (f3 == 3'd4 && $urandom_range(0, 1)) f3 = F3_LBU;
            return enc_i(imm, rs1, f3, rd, OP_LOAD);
         end
         8: return enc_s(imm, rs2, rs1, 3'($urandom_range(0, 2)));
         9: begin
            if (f3 == 3'd2 || f3 == 3'd3) f3 = f3 + 3'd4;
            return {imm[11], imm[9:4], rs2, rs1, f3, imm[3:0], imm[10], OP_BRANCH};
         end
         10: return {20'($urandom_range(0, 32'hfffff)), rd, OP_JAL};
         default: return enc_i(imm, rs1, 3'd0, rd, OP_JALR);
      endcase
   endfunction

   always @(negedge clock) begin : rsp_backpressure
      int hold;
      if (quiet) begin
         rsp_stall <= 0;
         hold = 0;
      end else if (hold > 0) begin
         hold = hold - 1;
         rsp_stall <= 1;
      end else if ($urandom_range(0, 5) == 0) begin
         hold = $urandom_range(0, 6);
         rsp_stall <= 1;
      end else rsp_stall <= 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin : result_check
      result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_next_pc, rsp_reg_write, rsp_reg_index, rsp_reg_value, rsp_store_done,
                rsp_mem_address, rsp_status, rsp_halt_code};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch expected: %p", want);
                  $display("         actual:   %p", got);
               end
            end
         end
      end
   end

   task automatic test_directed;
      send_instruction({20'h80000, 5'd1, OP_LUI});
      send_instruction(enc_i(12'hfff, 5'd0, F3_ADD, 5'd2, OP_IMM));
      send_instruction(enc_i(12'h7ff, 5'd2, F3_ADD, 5'd10, OP_IMM));
      send_instruction(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd3, OP_REG));
      send_instruction(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd4, OP_REG));
      send_instruction(enc_r(F7_MULDIV, 5'd0, 5'd1, F3_DIV, 5'd5, OP_REG));
      send_instruction(enc_r(F7_MULDIV, 5'd0, 5'd1, F3_REMU, 5'd6, OP_REG));
      send_instruction(enc_r(F7_MULDIV, 5'd0, 5'd2, F3_DIVU, 5'd7, OP_REG));
      send_instruction(enc_r(F7_MULDIV, 5'd0, 5'd2, F3_REM, 5'd8, OP_REG));
      send_instruction(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_MULH, 5'd9, OP_REG));
      send_instruction(enc_r(F7_MULDIV, 5'd2, 5'd2, F3_MULHU, 5'd11, OP_REG));
      send_instruction(enc_r(F7_BASE, 5'd2, 5'd2, F3_SLL, 5'd12, OP_REG));
      send_instruction(enc_r(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd13, OP_REG));
      send_instruction(enc_r(F7_BASE, 5'd2, 5'd1, F3_SR, 5'd14, OP_REG));
      send_instruction(enc_i(12'hfff, 5'd0, F3_ADD, 5'd0, OP_IMM));
      send_instruction(enc_s(12'hfff, 5'd1, 5'd2, F3_LW));
      send_instruction(enc_i(12'hfff, 5'd2, F3_LW, 5'd15, OP_LOAD));
      send_instruction(enc_i(12'h000, 5'd0, F3_LH, 5'd16, OP_LOAD));
      send_instruction(enc_i(12'hffe, 5'd2, F3_LB, 5'd17, OP_LOAD));
      send_instruction(enc_i(12'h001, 5'd0, F3_LBU, 5'd18, OP_LOAD));
      send_instruction({1'b1, 6'h3f, 5'd2, 5'd1, F3_BLT, 4'hf, 1'b1, OP_BRANCH});
      send_instruction({20'hfffff, 5'd19, OP_JAL});
      send_instruction(enc_i(12'h801, 5'd1, 3'd0, 5'd20, OP_JALR));
      send_instruction({20'hfffff, 5'd21, OP_AUIPC});
   endtask

   task automatic test_random(input int count);
      repeat (count) send_instruction(random_word());
   endtask

   task automatic test_stop;
      send_instruction($urandom_range(0, 1) ? EBREAK_WORD :
                       ($urandom_range(0, 1) ? ECALL_WORD : {25'($urandom), 7'h7f}));
      test_random(4);
   endtask

   initial begin
      arch_pc = 32'h80000000;
      cfg_start_pc = 32'h80000000;
      arch_halted = 0;
      for (int i = 0; i < 32; i++) arch_reg[i] = 0;
      for (int i = 0; i < MEM_BYTES; i++) arch_mem[i] = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;
      write_start_pc(32'h00000000);
      test_directed();
      drain();
      write_start_pc(32'hffffffff);
      test_random(250);
      drain();
      write_start_pc($urandom);
      test_random(250);
      drain();
      write_start_pc(32'h80000000);
      quiet = 1;
      test_random(280);
      test_stop();
      drain();
      if (mismatches == 0 && pending_results.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

FILE: rv32im_instruction_execute_core.f
sv/rvx_pkg.sv
sv/rvx_front.sv
sv/rvx_divider.sv
sv/rvx_back.sv
sv/rv32im_instruction_execute_core.sv
sim/tb_top.sv
